### design/tc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tc_pkg: tetrahedron circumsphere shared definitions
// Widths of the exact integer datapath, the front-to-back queue entry type
// and the back-end state encoding.
// ----------------------------------------------------------------------------
package tc_pkg;
	localparam int COORD_BITS      = 16;
	localparam int COORD_FRAC_BITS = 8;
	localparam int SH    = 16 - COORD_FRAC_BITS;
	localparam int CW    = COORD_BITS;
	localparam int EW    = CW + 1;
	localparam int SQW   = 2 * EW + 2;
	localparam int CRW   = 2 * EW + 1;
	localparam int DETW  = EW + CRW + 2;
	localparam int NUMW  = SQW + CRW + 2;
	localparam int TW    = NUMW + SH + 2;
	localparam int MAGW  = TW - 1;
	localparam int DENW  = DETW + 1;
	localparam int QW    = 33;
	localparam int DSHW  = DENW + QW;
	localparam int DW    = 34;
	localparam int SW    = 2 * DW + 2;
	localparam int RW    = SW / 2;
	localparam int RMW   = RW + 2;
	localparam int CNTW  = 6;
	localparam int QDEPTH = 4;
	localparam int QAW   = $clog2(QDEPTH);

	typedef struct packed {
		logic [2:0][MAGW-1:0] tmag;
		logic [2:0]           neg;
		logic [DENW-1:0]      den;
		logic                 deg;
		logic [2:0][CW-1:0]   p0;
	} q_entry_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIV  = 7'b0000010,
		S_CEN  = 7'b0000100,
		S_SQR  = 7'b0001000,
		S_SUM  = 7'b0010000,
		S_ROOT = 7'b0100000,
		S_DONE = 7'b1000000
	} back_state_t;
endpackage

### design/tetrahedron_circumsphere_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetrahedron_circumsphere_top: circumsphere of a tetrahedron
// Takes four Q8.8 vertices, returns the Q16.16 circumcenter and radius.
// ----------------------------------------------------------------------------
// A five-stage determinant pipeline accepts one tetrahedron per cycle, unless
// the queue is full and stalls it, into a four-entry queue; the back end takes
// one item at a time (a load step, bit-serial division for the three center
// coordinates run side by side, saturation, squaring and summing, 35
// square-root steps and an output step); a degenerate item skips straight to
// output. The serial divider and square-root unit set the sustained rate.
module tetrahedron_circumsphere_top import tc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] ax,
	input  logic [15:0] ay,
	input  logic [15:0] az,
	input  logic [15:0] bx,
	input  logic [15:0] by_coord,
	input  logic [15:0] bz,
	input  logic [15:0] cx_in,
	input  logic [15:0] cy_in,
	input  logic [15:0] cz_in,
	input  logic [15:0] dx_in,
	input  logic [15:0] dy_in,
	input  logic [15:0] dz_in,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] center_x,
	output logic [31:0] center_y,
	output logic [31:0] center_z,
	output logic [31:0] radius,
	output logic        degenerate,
	output logic        saturated
);
	q_entry_t qw_data, qr_data;
	logic     qw_push, q_full, q_pop, q_empty;

	tc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pa     ({az, ay, ax}),
		.pb     ({bz, by_coord, bx}),
		.pc     ({cz_in, cy_in, cx_in}),
		.pd     ({dz_in, dy_in, dx_in}),
		.q_push (qw_push),
		.q_full (q_full),
		.q_data (qw_data)
	);

	tc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (qw_push),
		.wdata   (qw_data),
		.q_full  (q_full),
		.rd      (q_pop),
		.rdata   (qr_data),
		.q_empty (q_empty)
	);

	tc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qd         (qr_data),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.center_x   (center_x),
		.center_y   (center_y),
		.center_z   (center_z),
		.radius     (radius),
		.degenerate (degenerate),
		.saturated  (saturated)
	);
endmodule

### design/tc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tc_front: determinant pipeline
// Five stages form the edge vectors, squared lengths, cross products, the
// determinant and the scaled center numerators, then hand off to the queue.
// ----------------------------------------------------------------------------
module tc_front import tc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [2:0][CW-1:0]   pa,
	input  logic [2:0][CW-1:0]   pb,
	input  logic [2:0][CW-1:0]   pc,
	input  logic [2:0][CW-1:0]   pd,
	output logic                 q_push,
	input  logic                 q_full,
	output q_entry_t             q_data
);
	logic signed [CW-1:0]   p_in [4][3];
	logic signed [EW-1:0]   e_s1 [3][3];
	logic signed [CW-1:0]   p0_s1 [3], p0_s2 [3], p0_s3 [3], p0_s4 [3], p0_s5 [3];
	logic signed [SQW-1:0]  sq_s2 [3];
	logic signed [CRW-1:0]  cr_s2 [3][3];
	logic signed [EW-1:0]   e0_s2 [3];
	logic signed [DETW-1:0] dp_s3 [3];
	logic signed [NUMW-1:0] np_s3 [3][3];
	logic signed [DETW-1:0] det_s4, det_s5;
	logic signed [NUMW-1:0] num_s4 [3];
	logic signed [TW-1:0]   t_s5 [3];
	logic signed [DETW-1:0] det_abs;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_in[0][k] = $signed(pa[k]);
			p_in[1][k] = $signed(pb[k]);
			p_in[2][k] = $signed(pc[k]);
			p_in[3][k] = $signed(pd[k]);
		end
	end

	assign adv    = !(v_s5 && q_full);
	assign full   = !adv;
	assign q_push = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				p0_s1[k] <= p_in[0][k];
				p0_s2[k] <= p0_s1[k];
				p0_s3[k] <= p0_s2[k];
				p0_s4[k] <= p0_s3[k];
				p0_s5[k] <= p0_s4[k];
				e0_s2[k] <= e_s1[0][k];
				dp_s3[k] <= DETW'(e0_s2[k] * cr_s2[0][k]);
				num_s4[k] <= np_s3[0][k] + np_s3[1][k] + np_s3[2][k];
				t_s5[k] <= TW'(p0_s4[k] * det_s4 * 2 + num_s4[k]) <<< SH;
			end
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					e_s1[i][k]  <= EW'(p_in[i+1][k]) - EW'(p_in[0][k]);
					np_s3[i][k] <= NUMW'(sq_s2[i] * cr_s2[i][k]);
				end
				sq_s2[i] <= SQW'(e_s1[i][0] * e_s1[i][0] + e_s1[i][1] * e_s1[i][1]
					+ e_s1[i][2] * e_s1[i][2]);
				cr_s2[i][0] <= CRW'(e_s1[(i+1)%3][1] * e_s1[(i+2)%3][2]
					- e_s1[(i+1)%3][2] * e_s1[(i+2)%3][1]);
				cr_s2[i][1] <= CRW'(e_s1[(i+1)%3][2] * e_s1[(i+2)%3][0]
					- e_s1[(i+1)%3][0] * e_s1[(i+2)%3][2]);
				cr_s2[i][2] <= CRW'(e_s1[(i+1)%3][0] * e_s1[(i+2)%3][1]
					- e_s1[(i+1)%3][1] * e_s1[(i+2)%3][0]);
			end
			det_s4 <= dp_s3[0] + dp_s3[1] + dp_s3[2];
			det_s5 <= det_s4;
		end
	end

	always_comb begin
		det_abs = det_s5[DETW-1] ? -det_s5 : det_s5;
		q_data.den = DENW'(det_abs) << 1;
		q_data.deg = (det_s5 == '0);
		for (int k = 0; k < 3; k++) begin
			q_data.tmag[k] = t_s5[k][TW-1] ? MAGW'(-t_s5[k]) : MAGW'(t_s5[k]);
			q_data.neg[k]  = t_s5[k][TW-1] ^ det_s5[DETW-1];
			q_data.p0[k]   = p0_s5[k];
		end
	end
endmodule

### design/tc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tc_queue: front-to-back decoupling queue
// Small register queue of determinant results between the two halves.
// ----------------------------------------------------------------------------
module tc_queue import tc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  q_entry_t wdata,
	output logic     q_full,
	input  logic     rd,
	output q_entry_t rdata,
	output logic     q_empty
);
	q_entry_t       mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic           do_wr, do_rd;

	assign q_full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end
endmodule

### design/tc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tc_back: divide and square-root engine
// Bit-serial division of the three center numerators, saturation, then a
// two-bits-per-step square root of the squared radius into the result register.
// ----------------------------------------------------------------------------
module tc_back import tc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_entry_t    qd,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] center_x,
	output logic [31:0] center_y,
	output logic [31:0] center_z,
	output logic [31:0] radius,
	output logic        degenerate,
	output logic        saturated
);
	back_state_t         state_q;
	logic [CNTW-1:0]     cnt_q;
	logic [2:0][DSHW-1:0] rem_q, dsh_q;
	logic [2:0][QW-1:0]  quo_q;
	logic [2:0]          ovf_q, neg_q;
	logic [2:0][CW-1:0]  p0_q;
	logic                deg_q, sat_q;
	logic [2:0][31:0]    cen_q;
	logic [2:0][SW-1:0]  sqr_q;
	logic [SW-1:0]       s_q;
	logic [RW-1:0]       root_q;
	logic [RMW-1:0]      srem_q;
	logic                out_v_q;
	logic [RMW-1:0]      trial, rnext;
	logic signed [DW-1:0] dd [3];
	logic                out_free;

	assign empty    = !out_v_q;
	assign out_free = !out_v_q || pop;
	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign trial    = {root_q, 2'b01};
	assign rnext    = {srem_q[RMW-3:0], s_q[SW-1:SW-2]};

	always_comb begin
		for (int k = 0; k < 3; k++)
			dd[k] = DW'($signed(cen_q[k])) - (DW'($signed(p0_q[k])) <<< SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (!q_empty) state_q <= qd.deg ? S_DONE : S_DIV;
				S_DIV:  if (cnt_q == '0) state_q <= S_CEN;
				S_CEN:  state_q <= S_SQR;
				S_SQR:  state_q <= S_SUM;
				S_SUM:  state_q <= S_ROOT;
				S_ROOT: if (cnt_q == '0) state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cnt_q <= CNTW'(QW - 1);
				deg_q <= qd.deg;
				sat_q <= 1'b0;
				cen_q <= '0;
				root_q <= '0;
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= DSHW'(qd.tmag[k]);
					dsh_q[k] <= DSHW'(qd.den) << (QW - 1);
					ovf_q[k] <= (DSHW+1)'(qd.tmag[k]) >= ((DSHW+1)'(qd.den) << QW);
					neg_q[k] <= qd.neg[k];
					quo_q[k] <= '0;
					p0_q[k]  <= qd.p0[k];
				end
			end
			S_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				for (int k = 0; k < 3; k++) begin
					if (rem_q[k] >= dsh_q[k]) begin
						rem_q[k] <= rem_q[k] - dsh_q[k];
						quo_q[k] <= {quo_q[k][QW-2:0], 1'b1};
					end else begin
						quo_q[k] <= {quo_q[k][QW-2:0], 1'b0};
					end
					dsh_q[k] <= dsh_q[k] >> 1;
				end
			end
			S_CEN: begin
				for (int k = 0; k < 3; k++) begin
					if (neg_q[k]) begin
						if (ovf_q[k] || quo_q[k] > QW'(33'h080000000)) begin
							cen_q[k] <= 32'h80000000;
							sat_q    <= 1'b1;
						end else begin
							cen_q[k] <= 32'(-quo_q[k]);
						end
					end else begin
						if (ovf_q[k] || quo_q[k] > QW'(33'h07FFFFFFF)) begin
							cen_q[k] <= 32'h7FFFFFFF;
							sat_q    <= 1'b1;
						end else begin
							cen_q[k] <= quo_q[k][31:0];
						end
					end
				end
			end
			S_SQR: begin
				for (int k = 0; k < 3; k++)
					sqr_q[k] <= SW'(dd[k] * dd[k]);
			end
			S_SUM: begin
				s_q    <= sqr_q[0] + sqr_q[1] + sqr_q[2];
				srem_q <= '0;
				root_q <= '0;
				cnt_q  <= CNTW'(RW - 1);
			end
			S_ROOT: begin
				cnt_q <= cnt_q - 1'b1;
				s_q   <= s_q << 2;
				if (rnext >= trial) begin
					srem_q <= rnext - trial;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					srem_q <= rnext;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			S_DONE: if (out_free) begin
				center_x   <= cen_q[0];
				center_y   <= cen_q[1];
				center_z   <= cen_q[2];
				degenerate <= deg_q;
				if (root_q[RW-1:32] != '0) begin
					radius    <= 32'hFFFFFFFF;
					saturated <= 1'b1;
				end else begin
					radius    <= root_q[31:0];
					saturated <= sat_q;
				end
			end
			default: cnt_q <= cnt_q;
		endcase
	end

`ifndef SYNTH
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !ovf_q[0]) |-> ((DSHW+1)'(rem_q[0]) < {dsh_q[0], 1'b0}))
		else $error("division remainder out of range");
	a_root_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT && cnt_q == '0) |=> (state_q == S_DONE))
		else $error("root iteration did not finish");
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && degenerate) |-> (radius == '0 && !saturated && center_x == '0))
		else $error("degenerate result carries data");
`endif
endmodule
